FILE: sv/qcmc_pkg.sv
`default_nettype none

package qcmc_pkg;

    // Request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_EMPTY = 2'd2
    } req_t;

    // Result status codes carried on the output tuser.
    typedef enum logic [1:0] {
        ST_BAL     = 2'd0,
        ST_SHORT   = 2'd1,
        ST_NO_UNIT = 2'd2,
        ST_IMBAL   = 2'd3
    } stat_t;

    // Passes of the clearing sequencer over the unit table.
    typedef enum logic [2:0] {
        P_SCAN      = 3'd0,
        P_BIS       = 3'd1,
        P_DISP      = 3'd2,
        P_FILL      = 3'd3,
        P_EMIT_CAP  = 3'd4,
        P_EMIT_ZERO = 3'd5,
        P_EMIT_BUF  = 3'd6,
        P_FAIL      = 3'd7
    } pass_t;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 168;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

FILE: sv/qcmc_ram.sv
`default_nettype none

module qcmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/quadratic_cost_market_clearing.sv
// Channel   Direction  Signals                              Contents
// s_axis    in         tvalid tready tdata[135:0] tuser[1:0] requests (load, clear, empty)
// m_axis    out        tvalid tready tdata[167:0] tuser[1:0] tlast  dispatch items
//
// A load or empty request is taken in the idle state. A clear request walks the unit
// table in several passes; each bisection step walks all MAX_UNITS slots and
// runs the one restoring divider in turn for each quadratic unit.
// Reset empties the unit table at once.
// s_axis_tready is low for the whole clear; a stalled m_axis holds the sequencer.
`default_nettype none

module quadratic_cost_market_clearing
    import qcmc_pkg::*;
#(
    parameter int MAX_UNITS    = 64,
    parameter int FRAC_BITS    = 16,
    parameter int BISECT_STEPS = 40
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: unit_slot, quad_coef, lin_coef, unit_capacity, demand, pad.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: req_type.
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Fields from bit 0: clearing_price, total_volume, shortfall, unit_index,
    // unit_output, unit_marginal_cost, pad.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: status.
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int IW  = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int AW  = $clog2(MAX_UNITS) + 33;
    localparam int DW  = 31 + FRAC_BITS;
    localparam int CW  = $clog2(DW);
    localparam int SCW = $clog2(BISECT_STEPS + 1);
    localparam int TOL = ((1 << FRAC_BITS) + 500) / 1000;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_USE  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_ACC  = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_OUT  = 9'b001000000,
        S_NEXT = 9'b010000000,
        S_BCHK = 9'b100000000
    } state_t;

    // Control registers.
    state_t                state_reg, state_next;
    pass_t                 pass_reg, pass_next;
    logic [MAX_UNITS-1:0]  mask_reg, mask_next;
    logic                  mvalid_reg, mvalid_next;

    // Working registers.
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         lastidx_reg, lastidx_next;
    logic                  any_reg, any_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic [31:0]           minb_reg, minb_next;
    logic [31:0]           pmax_reg, pmax_next;
    logic [31:0]           demand_reg, demand_next;
    logic [31:0]           rem_reg, rem_next;
    logic signed [33:0]    lo_reg, lo_next;
    logic signed [33:0]    hi_reg, hi_next;
    logic signed [33:0]    mid_reg, mid_next;
    logic [SCW-1:0]        step_reg, step_next;
    logic [31:0]           supply_reg, supply_next;
    logic [63:0]           prod_reg, prod_next;
    logic [DW-1:0]         num_reg, num_next;
    logic [DW-1:0]         quo_reg, quo_next;
    logic [31:0]           drem_reg, drem_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    // Result field registers.
    stat_t                 status_reg, status_next;
    logic [31:0]           price_reg, price_next;
    logic [31:0]           vol_reg, vol_next;
    logic [31:0]           sf_reg, sf_next;
    logic [5:0]            oidx_reg, oidx_next;
    logic [31:0]           ouo_reg, ouo_next;
    logic [31:0]           omc_reg, omc_next;
    logic                  olast_reg, olast_next;

    // Memory ports.
    logic                  ent_we;
    logic [IW-1:0]         ent_waddr;
    logic [95:0]           ent_rdata;
    logic                  obuf_we;
    logic [31:0]           obuf_rdata;

    // Combinational helpers.
    logic [31:0]           ua, ub, uc;
    logic                  loaded, usable;
    logic signed [33:0]    price_sel, pb;
    logic                  pb_pos;
    logic [63:0]           pshift;
    logic [64:0]           mcsum;
    logic [31:0]           mc;
    logic [32:0]           dr;
    logic                  dge;
    logic [DW-1:0]         qnew;
    logic [AW-1:0]         dem_ext, dem_minus_acc;
    logic [31:0]           acc_sat, outv;
    logic [IW-1:0]         slot_ix;

    assign ua      = ent_rdata[31:0];
    assign ub      = ent_rdata[63:32];
    assign uc      = ent_rdata[95:64];
    assign loaded  = mask_reg[idx_reg];
    assign usable  = loaded && (uc != 32'd0);
    assign slot_ix = s_axis_tdata[IW-1:0];
    assign ent_waddr = slot_ix;

    assign price_sel = (pass_reg == P_BIS) ? mid_reg : hi_reg;
    assign pb        = price_sel - $signed({2'b00, ub});
    assign pb_pos    = !pb[33] && (pb != 34'sd0);

    // Marginal cost from the registered product.
    assign pshift = prod_reg >> (FRAC_BITS - 1);
    assign mcsum  = {1'b0, pshift} + 65'(ub);
    assign mc     = (ua == 32'd0) ? ub :
                    ((mcsum > 65'(MAX32)) ? MAX32 : mcsum[31:0]);

    // One restoring divider step.
    assign dr   = {drem_reg, num_reg[DW-1]};
    assign dge  = dr >= {1'b0, ua};
    assign qnew = {quo_reg[DW-2:0], dge};

    assign dem_ext       = AW'(demand_reg);
    assign dem_minus_acc = dem_ext - acc_reg;
    assign acc_sat       = (acc_reg > AW'(MAX32)) ? MAX32 : acc_reg[31:0];

    always_comb
    begin
        unique case (pass_reg)
            P_EMIT_CAP:  outv = uc;
            P_EMIT_BUF:  outv = obuf_rdata;
            default:     outv = 32'd0;
        endcase
    end

    qcmc_ram #(.WIDTH(96), .DEPTH(MAX_UNITS)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata ({s_axis_tdata[101:70], s_axis_tdata[69:38], s_axis_tdata[37:6]}),
        .raddr (idx_reg),
        .rdata (ent_rdata)
    );

    qcmc_ram #(.WIDTH(32), .DEPTH(MAX_UNITS)) u_obuf_ram (
        .clk   (clk),
        .we    (obuf_we),
        .waddr (idx_reg),
        .wdata (supply_reg),
        .raddr (idx_reg),
        .rdata (obuf_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        mask_next    = mask_reg;
        mvalid_next  = mvalid_reg;
        idx_next     = idx_reg;
        lastidx_next = lastidx_reg;
        any_next     = any_reg;
        acc_next     = acc_reg;
        minb_next    = minb_reg;
        pmax_next    = pmax_reg;
        demand_next  = demand_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        step_next    = step_reg;
        supply_next  = supply_reg;
        prod_next    = prod_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        drem_next    = drem_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        price_next   = price_reg;
        vol_next     = vol_reg;
        sf_next      = sf_reg;
        oidx_next    = oidx_reg;
        ouo_next     = ouo_reg;
        omc_next     = omc_reg;
        olast_next   = olast_reg;
        ent_we       = 1'b0;
        obuf_we      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (req_t'(s_axis_tuser))
                        REQ_LOAD:
                        begin
                            if ({1'b0, s_axis_tdata[5:0]} < 7'(MAX_UNITS))
                            begin
                                ent_we             = 1'b1;
                                mask_next[slot_ix] = 1'b1;
                            end
                        end
                        REQ_EMPTY:
                        begin
                            mask_next = '0;
                        end
                        REQ_CLEAR:
                        begin
                            demand_next  = s_axis_tdata[133:102];
                            idx_next     = '0;
                            pass_next    = P_SCAN;
                            any_next     = 1'b0;
                            acc_next     = '0;
                            pmax_next    = '0;
                            minb_next    = MAX32;
                            lastidx_next = '0;
                            state_next   = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_USE;
            end

            S_USE:
            begin
                state_next = S_NEXT;
                unique case (pass_reg)
                    P_SCAN:
                    begin
                        if (loaded)
                        begin
                            lastidx_next = idx_reg;
                            if (uc != 32'd0)
                            begin
                                any_next = 1'b1;
                                acc_next = acc_reg + AW'(uc);
                                if (ub < minb_reg)
                                begin
                                    minb_next = ub;
                                end
                                prod_next  = 64'(ua) * 64'(uc);
                                state_next = S_MUL;
                            end
                        end
                    end
                    P_BIS, P_DISP:
                    begin
                        if (!usable)
                        begin
                            supply_next = 32'd0;
                            state_next  = (pass_reg == P_BIS) ? S_NEXT : S_ACC;
                        end
                        else if (ua == 32'd0)
                        begin
                            // Step offer: all or nothing at its price.
                            if (pass_reg == P_BIS)
                            begin
                                supply_next = !pb[33] ? uc : 32'd0;
                            end
                            else
                            begin
                                supply_next = pb_pos ? uc : 32'd0;
                            end
                            state_next = S_ACC;
                        end
                        else if (!pb_pos)
                        begin
                            supply_next = 32'd0;
                            state_next  = S_ACC;
                        end
                        else
                        begin
                            num_next   = DW'(pb[31:0]) << (FRAC_BITS - 1);
                            quo_next   = '0;
                            drem_next  = '0;
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    end
                    P_FILL:
                    begin
                        if (usable && (ua == 32'd0) && (hi_reg == $signed({2'b00, ub})))
                        begin
                            supply_next = (uc < rem_reg) ? uc : rem_reg;
                            state_next  = S_ACC;
                        end
                    end
                    P_EMIT_CAP, P_EMIT_ZERO, P_EMIT_BUF:
                    begin
                        if (loaded)
                        begin
                            supply_next = outv;
                            prod_next   = 64'(ua) * 64'(outv);
                            state_next  = S_MUL;
                        end
                    end
                    default:
                    begin
                        state_next = S_NEXT;
                    end
                endcase
            end

            S_DIV:
            begin
                num_next  = num_reg << 1;
                quo_next  = qnew;
                drem_next = dge ? 32'(dr - {1'b0, ua}) : dr[31:0];
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    supply_next = (qnew > DW'(uc)) ? uc : qnew[31:0];
                    state_next  = S_ACC;
                end
            end

            S_ACC:
            begin
                acc_next   = acc_reg + AW'(supply_reg);
                state_next = S_NEXT;
                if (pass_reg == P_DISP || pass_reg == P_FILL)
                begin
                    obuf_we = 1'b1;
                end
                if (pass_reg == P_FILL)
                begin
                    rem_next = rem_reg - supply_reg;
                end
            end

            S_MUL:
            begin
                if (pass_reg == P_SCAN)
                begin
                    if (mc > pmax_reg)
                    begin
                        pmax_next = mc;
                    end
                    state_next = S_NEXT;
                end
                else
                begin
                    oidx_next   = 6'(idx_reg);
                    ouo_next    = supply_reg;
                    omc_next    = mc;
                    olast_next  = (idx_reg == lastidx_reg);
                    mvalid_next = 1'b1;
                    state_next  = S_OUT;
                end
            end

            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    mvalid_next = 1'b0;
                    state_next  = (pass_reg == P_FAIL) ? S_IDLE : S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (idx_reg != IW'(MAX_UNITS - 1))
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_RD;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_RD;
                    unique case (pass_reg)
                        P_SCAN:
                        begin
                            if (!any_reg)
                            begin
                                // No usable unit: one all-zero item.
                                status_next = ST_NO_UNIT;
                                price_next  = '0;
                                vol_next    = '0;
                                sf_next     = '0;
                                oidx_next   = '0;
                                ouo_next    = '0;
                                omc_next    = '0;
                                olast_next  = 1'b1;
                                mvalid_next = 1'b1;
                                pass_next   = P_FAIL;
                                state_next  = S_OUT;
                            end
                            else if ((AW + 1)'(demand_reg) >
                                     (AW + 1)'(acc_reg) + (AW + 1)'(TOL))
                            begin
                                status_next = ST_SHORT;
                                price_next  = pmax_reg;
                                vol_next    = acc_sat;
                                sf_next     = dem_minus_acc[31:0];
                                pass_next   = P_EMIT_CAP;
                            end
                            else if (demand_reg <= 32'(TOL))
                            begin
                                status_next = ST_BAL;
                                price_next  = minb_reg;
                                vol_next    = '0;
                                sf_next     = '0;
                                pass_next   = P_EMIT_ZERO;
                            end
                            else
                            begin
                                lo_next    = $signed({2'b00, minb_reg}) - 34'sd1;
                                hi_next    = $signed({2'b00, pmax_reg});
                                step_next  = '0;
                                state_next = S_BCHK;
                            end
                        end
                        P_BIS:
                        begin
                            if (acc_reg < dem_ext)
                            begin
                                lo_next = mid_reg;
                            end
                            else
                            begin
                                hi_next = mid_reg;
                            end
                            step_next  = step_reg + SCW'(1);
                            state_next = S_BCHK;
                        end
                        P_DISP:
                        begin
                            rem_next  = (acc_reg < dem_ext) ? dem_minus_acc[31:0] : 32'd0;
                            pass_next = P_FILL;
                        end
                        P_FILL:
                        begin
                            if (((acc_reg > dem_ext) ? (acc_reg - dem_ext) : dem_minus_acc)
                                <= AW'(TOL))
                            begin
                                status_next = ST_BAL;
                            end
                            else
                            begin
                                status_next = ST_IMBAL;
                            end
                            price_next = hi_reg[31:0];
                            vol_next   = acc_sat;
                            sf_next    = '0;
                            pass_next  = P_EMIT_BUF;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_BCHK:
            begin
                idx_next   = '0;
                acc_next   = '0;
                state_next = S_RD;
                if (((hi_reg - lo_reg) <= 34'sd1) || (step_reg == SCW'(BISECT_STEPS)))
                begin
                    pass_next = P_DISP;
                end
                else
                begin
                    mid_next  = lo_reg + ((hi_reg - lo_reg) >>> 1);
                    pass_next = P_BIS;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pass_reg   <= P_SCAN;
            mask_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            mask_reg   <= mask_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        lastidx_reg <= lastidx_next;
        any_reg     <= any_next;
        acc_reg     <= acc_next;
        minb_reg    <= minb_next;
        pmax_reg    <= pmax_next;
        demand_reg  <= demand_next;
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        step_reg    <= step_next;
        supply_reg  <= supply_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        drem_reg    <= drem_next;
        cnt_reg     <= cnt_next;
        status_reg  <= status_next;
        price_reg   <= price_next;
        vol_reg     <= vol_next;
        sf_reg      <= sf_next;
        oidx_reg    <= oidx_next;
        ouo_reg     <= ouo_next;
        omc_reg     <= omc_next;
        olast_reg   <= olast_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {2'b00, omc_reg, ouo_reg, oidx_reg, sf_reg, vol_reg, price_reg};
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

`default_nettype wire

FILE: sv/qcmc_checker.sv
`default_nettype none

module qcmc_checker
    import qcmc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic [1:0]             s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]             m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // The block takes no request while an item waits on the output.
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while an item is pending");

    // A stalled item holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled item changed");

    // The no-unit result is a single all-zero closing item.
    a_no_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NO_UNIT) |->
            m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed no-unit item");

    // Shortfall is reported only with the shortfall status.
    a_sf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_SHORT) |-> (m_axis_tdata[95:64] == 32'd0))
        else $error("shortfall without shortfall status");

    // An item with last set closes the clear, so no item follows right after it.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("item followed the last item at once");

endmodule

bind quadratic_cost_market_clearing qcmc_checker u_qcmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
